FILE: design/tlbh_pkg.sv
// ----------------------------------------------------------------------------
// tlbh_pkg: shared types and constants for the two-level TLB
// Geometry of the L1 instruction/data TLBs and the L2 TLB, stream packing
// offsets, the hit-level codes and the controller command struct.
// ----------------------------------------------------------------------------
package tlbh_pkg;

    localparam int L1_INDEX_BITS = 4;
    localparam int L2_INDEX_BITS = 6;
    localparam int VPN_BITS      = 36;
    localparam int PPN_BITS      = 20;

    // L2 holds four times the lines of each L1
    localparam int LINK_BITS   = L2_INDEX_BITS - L1_INDEX_BITS;
    localparam int L1_LINES    = 1 << L1_INDEX_BITS;
    localparam int L2_LINES    = 1 << L2_INDEX_BITS;
    localparam int L1_TAG_BITS = VPN_BITS - L1_INDEX_BITS;
    localparam int L2_TAG_BITS = VPN_BITS - L2_INDEX_BITS;
    localparam int L1_ENTRY_W  = L1_TAG_BITS + PPN_BITS;
    localparam int L2_ENTRY_W  = L2_TAG_BITS + PPN_BITS;

    // Input stream: tdata = {walk_fault, walk_page, virtual_page}
    localparam int S_WPAGE_LSB = VPN_BITS;
    localparam int S_FAULT_BIT = VPN_BITS + PPN_BITS;
    localparam int S_TDATA_W   = ((VPN_BITS + PPN_BITS + 1 + 7) / 8) * 8;
    // Input stream: tuser = {is_instruction, mode}
    localparam int S_TUSER_W   = 2;
    localparam int S_MODE_BIT  = 0;
    localparam int S_INSTR_BIT = 1;

    // Output stream: tdata = {status, physical_page, hit_level, hit}
    localparam int M_FIELDS_W  = 1 + 2 + PPN_BITS + 1;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        LEVEL_NONE = 2'd0,
        LEVEL_L1   = 2'd1,
        LEVEL_L2   = 2'd2
    } level_t;

    typedef struct packed {
        logic capture;  // take the input item into the holding registers
        logic commit;   // update the tables and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic                status;
        logic [PPN_BITS-1:0] ppn;
        level_t              level;
        logic                hit;
    } result_t;

endpackage

FILE: design/tlbh_ram.sv
// ----------------------------------------------------------------------------
// tlbh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; no reset.
// ----------------------------------------------------------------------------
module tlbh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/tlbh_ctrl.sv
// ----------------------------------------------------------------------------
// tlbh_ctrl: item sequencer for the two-level TLB
// Accepts one item, lets the table reads settle, then commits the updates
// and the result once the output register is free.
// ----------------------------------------------------------------------------
module tlbh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tlbh_pkg::ctrl_cmd_t cmd
);
    import tlbh_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // commit only into a free or draining output register
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_capture_and_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

    a_capture_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !s_tready)
        else $error("input still ready after accepting an item");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.commit)
        else $error("result register overwritten while stalled");
`endif

endmodule

FILE: design/tlbh_dp.sv
// ----------------------------------------------------------------------------
// tlbh_dp: TLB datapath
// Holds the current item, the ITLB/DTLB/L2 tag-and-page RAMs with their valid
// bits, the hit logic, refill/fill/invalidate writes and the result register.
// ----------------------------------------------------------------------------
module tlbh_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tlbh_pkg::ctrl_cmd_t                 cmd,
    input  logic [tlbh_pkg::S_TDATA_W-1:0]      in_tdata,
    input  logic [tlbh_pkg::S_TUSER_W-1:0]      in_tuser,
    output tlbh_pkg::result_t                   result
);
    import tlbh_pkg::*;

    // held item
    logic                mode_reg;
    logic [VPN_BITS-1:0] vpn_reg;
    logic                instr_reg;
    logic [PPN_BITS-1:0] wpage_reg;
    logic                fault_reg;

    logic [L1_LINES-1:0] itlb_valid_reg;
    logic [L2_LINES-1:0] l2_valid_reg;
    logic [L1_LINES-1:0] dtlb_valid_reg;
    result_t             res_reg, res_next;

    logic [VPN_BITS-1:0]      in_vpn;
    logic [L1_INDEX_BITS-1:0] l1_raddr, i1;
    logic [L2_INDEX_BITS-1:0] l2_raddr, i2;
    logic [L1_TAG_BITS-1:0]   t1;
    logic [L2_TAG_BITS-1:0]   t2;
    logic [LINK_BITS-1:0]     link;

    logic [L1_ENTRY_W-1:0] it_rd, dt_rd, l1_wdata;
    logic [L2_ENTRY_W-1:0] l2_rd, l2_wdata;

    logic [L1_TAG_BITS-1:0] my_tag, ot_tag;
    logic [PPN_BITS-1:0]    my_page, l2_page;
    logic [L2_TAG_BITS-1:0] l2_tag;
    logic my_valid, l1_hit, l2_hit;
    logic refill, fill_ok, l1_write, l2_write, link_match;
    logic it_we, dt_we;

    assign in_vpn   = in_tdata[VPN_BITS-1:0];
    assign l1_raddr = cmd.capture ? in_vpn[L1_INDEX_BITS-1:0] : vpn_reg[L1_INDEX_BITS-1:0];
    assign l2_raddr = cmd.capture ? in_vpn[L2_INDEX_BITS-1:0] : vpn_reg[L2_INDEX_BITS-1:0];

    assign i1   = vpn_reg[L1_INDEX_BITS-1:0];
    assign i2   = vpn_reg[L2_INDEX_BITS-1:0];
    assign t1   = vpn_reg[VPN_BITS-1:L1_INDEX_BITS];
    assign t2   = vpn_reg[VPN_BITS-1:L2_INDEX_BITS];
    assign link = vpn_reg[L2_INDEX_BITS-1:L1_INDEX_BITS];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_tuser[S_MODE_BIT];
            instr_reg <= in_tuser[S_INSTR_BIT];
            vpn_reg   <= in_vpn;
            wpage_reg <= in_tdata[S_WPAGE_LSB +: PPN_BITS];
            fault_reg <= in_tdata[S_FAULT_BIT];
        end
    end

    tlbh_ram #(.WIDTH(L1_ENTRY_W), .DEPTH(L1_LINES)) u_itlb_ram (
        .aclk    (aclk),
        .wr_en   (it_we),
        .wr_addr (i1),
        .wr_data (l1_wdata),
        .rd_addr (l1_raddr),
        .rd_data (it_rd)
    );

    tlbh_ram #(.WIDTH(L1_ENTRY_W), .DEPTH(L1_LINES)) u_dtlb_ram (
        .aclk    (aclk),
        .wr_en   (dt_we),
        .wr_addr (i1),
        .wr_data (l1_wdata),
        .rd_addr (l1_raddr),
        .rd_data (dt_rd)
    );

    tlbh_ram #(.WIDTH(L2_ENTRY_W), .DEPTH(L2_LINES)) u_l2_ram (
        .aclk    (aclk),
        .wr_en   (l2_write),
        .wr_addr (i2),
        .wr_data (l2_wdata),
        .rd_addr (l2_raddr),
        .rd_data (l2_rd)
    );

    // entries are {tag, page}
    always_comb begin
        if (instr_reg) begin
            my_valid = itlb_valid_reg[i1];
            my_tag   = it_rd[L1_ENTRY_W-1:PPN_BITS];
            my_page  = it_rd[PPN_BITS-1:0];
            ot_tag   = dt_rd[L1_ENTRY_W-1:PPN_BITS];
        end else begin
            my_valid = dtlb_valid_reg[i1];
            my_tag   = dt_rd[L1_ENTRY_W-1:PPN_BITS];
            my_page  = dt_rd[PPN_BITS-1:0];
            ot_tag   = it_rd[L1_ENTRY_W-1:PPN_BITS];
        end
    end

    assign l2_tag  = l2_rd[L2_ENTRY_W-1:PPN_BITS];
    assign l2_page = l2_rd[PPN_BITS-1:0];

    assign l1_hit     = my_valid && (my_tag == t1);
    assign l2_hit     = l2_valid_reg[i2] && (l2_tag == t2);
    assign refill     = !mode_reg && !l1_hit && l2_hit;
    assign fill_ok    = mode_reg && !fault_reg;
    // other L1 entry points at the L2 line being replaced
    assign link_match = (ot_tag[LINK_BITS-1:0] == link);

    assign l1_write = cmd.commit && (refill || fill_ok);
    assign l2_write = cmd.commit && fill_ok;
    assign it_we    = l1_write && instr_reg;
    assign dt_we    = l1_write && !instr_reg;
    assign l1_wdata = {t1, (mode_reg ? wpage_reg : l2_page)};
    assign l2_wdata = {t2, wpage_reg};

    always_comb begin
        res_next = '0;
        if (mode_reg) begin
            res_next.status = fault_reg;
            res_next.ppn    = fault_reg ? '0 : wpage_reg;
        end else if (l1_hit) begin
            res_next.hit   = 1'b1;
            res_next.level = LEVEL_L1;
            res_next.ppn   = my_page;
        end else if (l2_hit) begin
            res_next.hit   = 1'b1;
            res_next.level = LEVEL_L2;
            res_next.ppn   = l2_page;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            itlb_valid_reg <= '0;
            dtlb_valid_reg <= '0;
            l2_valid_reg   <= '0;
        end else if (cmd.commit) begin
            if (l2_write) begin
                l2_valid_reg[i2] <= 1'b1;
            end
            if (it_we) begin
                itlb_valid_reg[i1] <= 1'b1;
            end
            if (dt_we) begin
                dtlb_valid_reg[i1] <= 1'b1;
            end
            // drop the other L1's stale link, valid or not
            if (fill_ok && link_match) begin
                if (instr_reg) begin
                    dtlb_valid_reg[i1] <= 1'b0;
                end else begin
                    itlb_valid_reg[i1] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

`ifndef SYNTHESIS
    a_fill_sets_l2_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && fill_ok) |=> l2_valid_reg[$past(i2)])
        else $error("fill did not validate the L2 line");

    a_hit_level_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (res_reg.hit == (res_reg.level != LEVEL_NONE)))
        else $error("hit flag and hit level disagree");

    a_fault_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> !(res_reg.status && (res_reg.hit || (res_reg.ppn != '0))))
        else $error("fault result carries a translation");

    a_refill_sets_l1_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && refill && instr_reg) |=> itlb_valid_reg[$past(i1)])
        else $error("L2 hit did not refill the ITLB");
`endif

endmodule

FILE: design/two_level_tlb_hierarchy_top.sv
// ----------------------------------------------------------------------------
// two_level_tlb_hierarchy_top: two-level TLB with split L1 and shared L2
// Direct-mapped ITLB and DTLB backed by a direct-mapped L2 TLB. Lookups check
// the L1 picked by the access type, then L2 (an L2 hit refills that L1).
// Fills write L2 and the chosen L1, or report a walk fault.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-----------------------------------
//   s_      | in  | s_tvalid / s_tready | tdata, tuser: lookup or fill item
//   m_      | out | m_tvalid / m_tready | tdata: one result item per input
//
// Each item is taken in ST_IDLE, whose accept cycle issues the registered reads
// of the three tag/page RAMs; ST_EXEC then compares, writes and loads the
// result register. The registered RAM read port is why ST_EXEC exists.
// Reset (aresetn low, synchronous) clears all valid bits at once; no sweep.
// A new item is taken while a result waits in the output register; a stalled
// result holds the next item in its execute cycle until m_tready frees it.
// ----------------------------------------------------------------------------
module two_level_tlb_hierarchy_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: virtual_page, walk_page, walk_fault, zero pad
    input  logic [tlbh_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser from bit 0: mode, is_instruction
    input  logic [tlbh_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: hit, hit_level, physical_page, status
    output logic [tlbh_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tlbh_pkg::*;

    ctrl_cmd_t cmd;
    result_t   result;

    // sequence: accept, execute, hand off to the output register
    tlbh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // tables, hit logic and the result register
    tlbh_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_tdata (s_tdata),
        .in_tuser (s_tuser),
        .result   (result)
    );

    // pack the result, hit in the low bit, zero-fill to whole bytes
    assign m_tdata = M_TDATA_W'({result.status, result.ppn, result.level, result.hit});

endmodule
